// File: src/fgn_pkg.sv
// Shared constants, codes and control types of the fractal gradient noise block.
package fgn_pkg;

	localparam int DEF_MAX_OCTAVES = 8;
	localparam int DEF_FRAC_BITS   = 16;

	localparam logic [31:0] HX_MUL = 32'd1619;
	localparam logic [31:0] HY_MUL = 32'd31337;
	localparam logic [31:0] HZ_MUL = 32'd6971;
	localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
	localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

	localparam logic [31:0] SEED_RST = 32'd5;
	localparam logic [3:0]  OCT_RST  = 4'd1;
	localparam logic [31:0] FREQ_RST = 32'd65536;

	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] CFG_SEED    = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_OCTAVES = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_FREQ    = 2'd2;

	localparam int QW = 15;
	localparam logic [QW-1:0] Q_ONE = 15'd16384;

	localparam logic [3:0] N_PMUL   = 4'd2;
	localparam logic [3:0] N_HASH   = 4'd7;
	localparam logic [3:0] N_FADE   = 4'd8;
	localparam logic [3:0] N_LERP   = 4'd6;
	localparam logic [3:0] N_DIV    = 4'd14;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_PMUL, OP_SPLIT, OP_HASH, OP_FADE,
		OP_LERP, OP_ACC, OP_DIVI, OP_DIV, OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] k;
	} cmd_t;

	typedef struct packed {
		logic last_oct;
		logic out_busy;
	} stat_t;

endpackage

// File: src/fgn_if.sv
// Point and noise channel interfaces.
interface fgn_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	modport source(output valid, pos_x, pos_y, pos_z, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface fgn_noise_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] noise_value;
	modport source(output valid, noise_value, input ready);
	modport sink(input valid, noise_value, output ready);
endinterface

// File: src/fgn_ctrl.sv
// Sequencer that steps the noise datapath through octaves and the final divide.
module fgn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fgn_pkg::stat_t stat,
	output fgn_pkg::cmd_t  cmd
);
	import fgn_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PMUL  = 4'd1;
	localparam logic [3:0] S_SPLIT = 4'd2;
	localparam logic [3:0] S_HASH  = 4'd3;
	localparam logic [3:0] S_FADE  = 4'd4;
	localparam logic [3:0] S_LERP  = 4'd5;
	localparam logic [3:0] S_ACC   = 4'd6;
	localparam logic [3:0] S_DIVI  = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + 4'd1;
		cmd.op  = OP_NONE;
		cmd.k   = cnt_q;
		case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_PMUL;
				end
			end
			S_PMUL: begin
				cmd.op = OP_PMUL;
				if (cnt_q == N_PMUL) state_d = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.op  = OP_SPLIT;
				cnt_d   = '0;
				state_d = S_HASH;
			end
			S_HASH: begin
				cmd.op = OP_HASH;
				if (cnt_q == N_HASH) begin
					cnt_d   = '0;
					state_d = S_FADE;
				end
			end
			S_FADE: begin
				cmd.op = OP_FADE;
				if (cnt_q == N_FADE) begin
					cnt_d   = '0;
					state_d = S_LERP;
				end
			end
			S_LERP: begin
				cmd.op = OP_LERP;
				if (cnt_q == N_LERP) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op  = OP_ACC;
				state_d = stat.last_oct ? S_DIVI : S_SPLIT;
			end
			S_DIVI: begin
				cmd.op  = OP_DIVI;
				cnt_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (cnt_q == N_DIV) state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the output register can take the item
				if (!stat.out_busy) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: src/fgn_dp.sv
// Noise datapath: scaling, corner hash pipe, fade and lerp multiplier, divider.
module fgn_dp #(
	parameter int MAX_OCTAVES = fgn_pkg::DEF_MAX_OCTAVES,
	parameter int FRAC_BITS   = fgn_pkg::DEF_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fgn_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]                cfg_data,
	input  logic signed [31:0]         pos_x,
	input  logic signed [31:0]         pos_y,
	input  logic signed [31:0]         pos_z,
	input  fgn_pkg::cmd_t              cmd,
	output fgn_pkg::stat_t             stat,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [15:0]         out_value
);
	import fgn_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int DW  = F + 3;
	localparam int AW  = DW + MAX_OCTAVES;
	localparam int RW  = AW + 16;
	localparam int OW  = $clog2(MAX_OCTAVES + 1);
	localparam int PW  = F + 5;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	logic [31:0] seed_q, freq_q;
	logic [3:0]  octs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RST;
			octs_q <= OCT_RST;
			freq_q <= FREQ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEED:    seed_q <= cfg_data;
				CFG_OCTAVES: octs_q <= cfg_data[3:0];
				CFG_FREQ:    freq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [OW-1:0] n_cfg, n_q, oct_q;
	always_comb begin
		if (octs_q == '0) n_cfg = OW'(1);
		else if (32'(octs_q) > 32'(MAX_OCTAVES)) n_cfg = OW'(MAX_OCTAVES);
		else n_cfg = OW'(octs_q);
	end

	logic signed [31:0] pos_q [3];
	logic [63:0]        prod_q [3];
	logic [31:0]        hx0_q [3];
	logic [F-1:0]       t_q [3];
	logic [F:0]         fade_q [3];
	logic [F-1:0]       t2_q, t3_q;
	logic signed [DW-1:0] d_q [8];
	logic signed [AW-1:0] acc_q;

	// shared multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;
	assign mp = ma * mb;

	logic [1:0]   fa, fp;
	logic [F-1:0] ft;
	logic [PW-1:0] p_u;
	logic [F:0]   lw;
	logic signed [DW:0] ldiff;
	logic signed [65:0] lsh;
	logic signed [DW-1:0] lres;
	logic [PW-1:0] fr;
	logic [F:0]   fnew;

	always_comb begin
		case (cmd.k) inside
			[4'd0:4'd2]: fa = 2'd0;
			[4'd3:4'd5]: fa = 2'd1;
			default:     fa = 2'd2;
		endcase
		fp = 2'(cmd.k - 4'(3 * fa));
		ft = t_q[fa];
		p_u = (PW'(10) << F) + PW'(6) * PW'(t2_q) - PW'(15) * PW'(ft);
		case (cmd.k) inside
			[4'd0:4'd3]: lw = fade_q[0];
			[4'd4:4'd5]: lw = fade_q[1];
			default:     lw = fade_q[2];
		endcase
		ldiff = (DW+1)'(d_q[1]) - (DW+1)'(d_q[0]);
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_PMUL: begin
				ma = 33'(pos_q[cmd.k[1:0]]);
				mb = $signed({1'b0, freq_q});
			end
			OP_FADE: begin
				case (fp)
					2'd0: begin
						ma = $signed(33'(ft));
						mb = $signed(33'(ft));
					end
					2'd1: begin
						ma = $signed(33'(t2_q));
						mb = $signed(33'(ft));
					end
					default: begin
						ma = $signed(33'(t3_q));
						mb = $signed(33'(p_u));
					end
				endcase
			end
			OP_LERP: begin
				ma = 33'(ldiff);
				mb = $signed(33'(lw));
			end
			default: ;
		endcase
		lsh  = mp >>> F;
		lres = d_q[0] + $signed(lsh[DW-1:0]);
		fr   = mp[F +: PW];
		fnew = (fr > PW'(ONE)) ? ONE : fr[F:0];
	end

	// corner hash pipe
	logic [31:0] h0, ha, m1_s1, hb, m2_s2, hf;
	logic [2:0]  idx_s1, idx_s2;
	logic        v_s1, v_s2;
	logic signed [DW-1:0] dot, off;

	always_comb begin
		h0 = seed_q ^ (cmd.k[0] ? hx0_q[0] + HX_MUL : hx0_q[0])
			^ (cmd.k[1] ? hx0_q[1] + HY_MUL : hx0_q[1])
			^ (cmd.k[2] ? hx0_q[2] + HZ_MUL : hx0_q[2]);
		ha = h0 ^ (h0 >> 16);
		hb = m1_s1 ^ (m1_s1 >> 13);
		hf = m2_s2 ^ (m2_s2 >> 16);
		dot = '0;
		for (int a = 0; a < 3; a++) begin
			off = idx_s2[a] ? $signed(DW'(t_q[a])) - $signed(DW'(ONE))
				: $signed(DW'(t_q[a]));
			if (32'(hf[4:3]) != a) dot = hf[a] ? dot + off : dot - off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (cmd.op == OP_HASH);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		m1_s1  <= ha * MIX_C1;
		idx_s1 <= cmd.k[2:0];
		m2_s2  <= hb * MIX_C2;
		idx_s2 <= idx_s1;
	end

	// divider
	logic [RW-1:0] rem_q, dsh_q, den_w, rem_init;
	logic [AW-1:0] mag;
	logic [QW-1:0] q_q, qc;
	logic          neg_q, sat_q;

	always_comb begin
		den_w    = ((RW'(1) << n_q) - RW'(1)) << F;
		mag      = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
		rem_init = (RW'(mag) << 14) + (den_w >> 1);
		qc       = (sat_q || q_q > Q_ONE) ? Q_ONE : q_q;
	end

	assign stat.last_oct = (oct_q == n_q - OW'(1));
	assign stat.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				pos_q[0] <= pos_x;
				pos_q[1] <= pos_y;
				pos_q[2] <= pos_z;
				n_q      <= n_cfg;
				oct_q    <= '0;
				acc_q    <= '0;
			end
			OP_PMUL: prod_q[cmd.k[1:0]] <= mp[63:0];
			OP_SPLIT: begin
				hx0_q[0] <= 32'((prod_q[0] << oct_q) >> 32) * HX_MUL;
				hx0_q[1] <= 32'((prod_q[1] << oct_q) >> 32) * HY_MUL;
				hx0_q[2] <= 32'((prod_q[2] << oct_q) >> 32) * HZ_MUL;
				for (int a = 0; a < 3; a++) t_q[a] <= F'((prod_q[a] << oct_q) >> (32 - F));
			end
			OP_FADE: begin
				case (fp)
					2'd0:    t2_q <= mp[F +: F];
					2'd1:    t3_q <= mp[F +: F];
					default: fade_q[fa] <= fnew;
				endcase
			end
			OP_LERP: begin
				for (int i = 0; i < 6; i++)
					if (3'(i) != 3'(4'd6 - cmd.k)) d_q[i] <= d_q[i+2];
				d_q[3'(4'd6 - cmd.k)] <= lres;
			end
			OP_ACC: begin
				acc_q <= (acc_q <<< 1) + AW'(d_q[0]);
				oct_q <= oct_q + OW'(1);
			end
			OP_DIVI: begin
				neg_q <= acc_q[AW-1];
				rem_q <= rem_init;
				sat_q <= rem_init >= (den_w << 15);
				dsh_q <= den_w << 14;
				q_q   <= '0;
			end
			OP_DIV: begin
				if (rem_q >= dsh_q) rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[QW-2:0], rem_q >= dsh_q};
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
		// the last hash results land while the fade steps run
		if (v_s2) d_q[idx_s2] <= dot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.op == OP_OUT) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) out_value <= neg_q ? -$signed(16'(qc)) : $signed(16'(qc));
	end

endmodule

// File: src/fractal_gradient_noise_3d.sv
// Top level of the fractal 3D gradient noise block.
//   channel  | dir | payload                   | accepted when
//   point    | in  | pos_x, pos_y, pos_z Q16.16 | point.valid && point.ready
//   noise    | out | noise_value Q2.14          | noise.valid && noise.ready
//   cfg      | in  | cfg_index, cfg_data        | cfg_we
// Per octave: 1 split, 8 corner issues into the s1/s2 hash pipe, 9 fade and 7 lerp
// steps on the one shared multiplier, 1 accumulate; then a 15-step restoring divider.
// Reset returns the registers to seed 5, one octave, frequency 1.0; no clearing pass.
// The result waits in an output register, and a new item is taken once it is parked.
module fractal_gradient_noise_3d #(
	parameter int MAX_OCTAVES = fgn_pkg::DEF_MAX_OCTAVES,
	parameter int FRAC_BITS   = fgn_pkg::DEF_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fgn_point_if.sink                  point,
	fgn_noise_if.source                noise,
	input  logic                       cfg_we,
	input  logic [fgn_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]                cfg_data
);
	import fgn_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	fgn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(point.valid), .in_ready(point.ready),
		.stat(stat), .cmd(cmd)
	);

	fgn_dp #(.MAX_OCTAVES(MAX_OCTAVES), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pos_x(point.pos_x), .pos_y(point.pos_y),
		.pos_z(point.pos_z), .cmd(cmd), .stat(stat), .out_valid(noise.valid),
		.out_ready(noise.ready), .out_value(noise.noise_value)
	);

endmodule

// File: src/fgn_checker.sv
// Port-level checks of the noise block, bound to the top level.
module fgn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] out_value
);
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("point taken while an item is in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after an item was taken");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_value >= -16'sd16384 && out_value <= 16'sd16384)
		else $error("noise value beyond unit range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("stalled item changed");
endmodule

bind fractal_gradient_noise_3d fgn_checker u_fgn_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(point.valid), .in_ready(point.ready),
	.out_valid(noise.valid), .out_ready(noise.ready), .out_value(noise.noise_value)
);

// File: bench/fractal_gradient_noise_3d_tb.sv
// Self-checking bench for the fractal 3D gradient noise block: directed table, random points.
module fractal_gradient_noise_3d_tb;
	import fgn_pkg::*;

	localparam int FB = 16;
	localparam longint ONE = 64'sd1 << FB;
	localparam int WATCH_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [31:0] cfg_data;

	fgn_point_if point();
	fgn_noise_if noise();

	fractal_gradient_noise_3d i_dut (
		.clk(clk), .arst_n(arst_n), .point(point), .noise(noise),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the registers
	logic [31:0] seed_q;
	logic [3:0]  oct_q;
	logic [31:0] freq_q;

	logic signed [15:0] noise_q[$];
	int errors;
	int sent;
	int received;
	int idle_pct_in;
	int idle_pct_out;
	int hold_out;
	int quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shift(longint v);
		return v >>> FB;
	endfunction

	function automatic logic [31:0] mix_hash(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		logic [31:0] h;
		h = seed_q;
		h ^= x * 32'd1619;
		h ^= y * 32'd31337;
		h ^= z * 32'd6971;
		h ^= h >> 16;
		h *= 32'h85ebca6b;
		h ^= h >> 13;
		h *= 32'hc2b2ae35;
		h ^= h >> 16;
		return h;
	endfunction

	function automatic longint grad_dot(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			longint dx, longint dy, longint dz);
		logic [31:0] h;
		longint gx, gy, gz;
		h = mix_hash(cx, cy, cz);
		gx = h[0] ? 1 : -1;
		gy = h[1] ? 1 : -1;
		gz = h[2] ? 1 : -1;
		case (h[4:3])
			2'd0: gx = 0;
			2'd1: gy = 0;
			2'd2: gz = 0;
			default: ;
		endcase
		return gx * dx + gy * dy + gz * dz;
	endfunction

	function automatic longint quintic(longint t);
		longint t2, t3, p, f;
		t2 = (t * t) >>> FB;
		t3 = (t2 * t) >>> FB;
		p = 6 * t2 - 15 * t + 10 * ONE;
		f = (t3 * p) >>> FB;
		return (f > ONE) ? ONE : f;
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		return a + floor_shift((b - a) * w);
	endfunction

	function automatic void lattice(logic signed [31:0] pos, int oct,
			output logic [31:0] lat, output longint frac);
		logic [63:0] p;
		p = longint'(pos) * longint'({32'd0, freq_q});
		p = p << oct;
		lat = p[63:32];
		frac = longint'(p[31:32-FB]);
	endfunction

	function automatic longint octave_value(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, int oct);
		logic [31:0] x0, y0, z0, x1, y1, z1;
		longint lx, ly, lz, mx, my, mz, u, v, w;
		longint d[8];
		longint a00, a01, a10, a11, b0, b1;
		lattice(px, oct, x0, lx);
		lattice(py, oct, y0, ly);
		lattice(pz, oct, z0, lz);
		x1 = x0 + 1; y1 = y0 + 1; z1 = z0 + 1;
		mx = lx - ONE; my = ly - ONE; mz = lz - ONE;
		d[0] = grad_dot(x0, y0, z0, lx, ly, lz);
		d[1] = grad_dot(x1, y0, z0, mx, ly, lz);
		d[2] = grad_dot(x0, y1, z0, lx, my, lz);
		d[3] = grad_dot(x1, y1, z0, mx, my, lz);
		d[4] = grad_dot(x0, y0, z1, lx, ly, mz);
		d[5] = grad_dot(x1, y0, z1, mx, ly, mz);
		d[6] = grad_dot(x0, y1, z1, lx, my, mz);
		d[7] = grad_dot(x1, y1, z1, mx, my, mz);
		u = quintic(lx); v = quintic(ly); w = quintic(lz);
		a00 = blend(d[0], d[1], u);
		a01 = blend(d[4], d[5], u);
		a10 = blend(d[2], d[3], u);
		a11 = blend(d[6], d[7], u);
		b0 = blend(a00, a10, v);
		b1 = blend(a01, a11, v);
		return blend(b0, b1, w);
	endfunction

	function automatic logic signed [15:0] fbm_noise(logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		int n;
		longint acc, den, mag, q;
		n = oct_q;
		if (n < 1) n = 1;
		if (n > DEF_MAX_OCTAVES) n = DEF_MAX_OCTAVES;
		acc = 0;
		for (int i = 0; i < n; i++)
			acc += octave_value(px, py, pz, i) * (64'sd1 << (n - 1 - i));
		den = ((64'sd1 << n) - 1) * ONE;
		mag = ((acc < 0) ? -acc : acc) * 16384;
		q = (mag + den / 2) / den;
		if (q > 16384) q = 16384;
		return (acc < 0) ? 16'(-q) : 16'(q);
	endfunction

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_SEED:    seed_q = val;
			CFG_OCTAVES: oct_q = val[3:0];
			CFG_FREQ:    freq_q = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// offer one item; hold until accepted
	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, bit has_exp, logic signed [15:0] exp_val);
		while ($urandom_range(99) < idle_pct_in) begin
			point.valid <= 1'b0;
			@(posedge clk);
		end
		point.valid <= 1'b1;
		point.pos_x <= x;
		point.pos_y <= y;
		point.pos_z <= z;
		noise_q.push_back(has_exp ? exp_val : fbm_noise(x, y, z));
		@(posedge clk);
		while (!point.ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		point.valid <= 1'b0;
		while (noise_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// receiver side
	always @(posedge clk) begin
		if (hold_out > 0) begin
			hold_out <= hold_out - 1;
			noise.ready <= 1'b0;
		end else begin
			noise.ready <= ($urandom_range(99) >= idle_pct_out);
		end
		if (noise.valid && noise.ready) begin
			received++;
			if (noise_q.size() == 0) begin
				$display("%0t: unexpected noise item, actual %0d", $time, noise.noise_value);
				errors++;
			end else begin
				if (noise.noise_value !== noise_q[0]) begin
					$display("%0t: noise_value expected %0d actual %0d",
						$time, noise_q[0], noise.noise_value);
					errors++;
				end
				void'(noise_q.pop_front());
			end
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((point.valid && point.ready) || (noise.valid && noise.ready) || cfg_we
				|| noise_q.size() == 0)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	typedef struct {
		logic signed [31:0] x, y, z;
		bit has_exp;
		logic signed [15:0] val;
	} row_t;

	row_t directed[] = '{
		'{32'sd0, 32'sd0, 32'sd0, 1'b1, 16'sd0},                        // lattice corner
		'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 16'sd0},
		'{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, 16'sd0},
		'{32'sh00008000, 32'sh00008000, 32'sh00008000, 1'b0, 16'sd0},
		'{32'sh0000ffff, 32'shffff0001, 32'sh00010000, 1'b0, 16'sd0},
		'{32'shffffffff, 32'sh00000001, 32'sh55555555, 1'b0, 16'sd0},
		'{32'shaaaaaaaa, 32'sh12345678, 32'shfedcba98, 1'b0, 16'sd0},
		'{32'sh00030000, 32'shfffd0000, 32'sh00000000, 1'b1, 16'sd0}     // all integer
	};

	initial begin
		int k;
		logic signed [31:0] rx, ry, rz;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		point.valid = 1'b0; point.pos_x = '0; point.pos_y = '0; point.pos_z = '0;
		noise.ready = 1'b0;
		seed_q = SEED_RST; oct_q = OCT_RST; freq_q = FREQ_RST;
		errors = 0; sent = 0; received = 0; quiet = 0;
		idle_pct_in = 0; idle_pct_out = 0; hold_out = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings, then at the extremes
		foreach (directed[i])
			send_point(directed[i].x, directed[i].y, directed[i].z,
				directed[i].has_exp, directed[i].val);
		drain();
		write_reg(CFG_OCTAVES, 32'd8);
		write_reg(CFG_SEED, 32'hffffffff);
		write_reg(CFG_FREQ, 32'hffffffff);
		foreach (directed[i])
			if (i > 0) send_point(directed[i].x, directed[i].y, directed[i].z, 1'b0, 16'sd0);
		drain();
		write_reg(CFG_FREQ, 32'd0);                          // zero frequency gives zero
		send_point(32'sh12345678, 32'sh87654321, 32'sh0badf00d, 1'b1, 16'sd0);
		drain();
		write_reg(CFG_OCTAVES, 32'd0);                       // zero octaves act as one
		write_reg(CFG_FREQ, 32'h00018000);
		send_point(32'sh00014000, 32'sh00002000, 32'shfffe8000, 1'b0, 16'sd0);
		drain();
		write_reg(CFG_OCTAVES, 32'd15);                      // saturates to the maximum
		write_reg(CFG_SEED, 32'd0);
		send_point(32'sh00014000, 32'sh00002000, 32'shfffe8000, 1'b0, 16'sd0);
		drain();

		// random phases: settings and idling vary per phase
		for (int ph = 0; ph < 11; ph++) begin
			write_reg(CFG_SEED, $urandom);
			write_reg(CFG_OCTAVES, (ph % 3 == 0) ? $urandom_range(15, 0) : $urandom_range(3, 1));
			write_reg(CFG_FREQ, (ph % 4 == 0) ? $urandom : $urandom_range(32'h40000, 32'h100));
			case (ph % 4)
				0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
				1: begin idle_pct_in = 80; idle_pct_out = 0;  end
				2: begin idle_pct_in = 0;  idle_pct_out = 80; end
				default: begin idle_pct_in = 21; idle_pct_out = 21; end
			endcase
			if (ph == 4) hold_out = 600;                     // long receiver hold-off
			for (k = 0; k < 48; k++) begin
				rx = $urandom; ry = $urandom; rz = $urandom;
				if ($urandom_range(3) != 0) begin
					rx = $signed(rx) >>> $urandom_range(20, 8);
					ry = $signed(ry) >>> $urandom_range(20, 8);
					rz = $signed(rz) >>> $urandom_range(20, 8);
				end
				send_point(rx, ry, rz, 1'b0, 16'sd0);
			end
			drain();
		end

		$display("covered %0d points, %0d results, octave counts 0..15, seed and frequency extremes",
			sent, received);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// File: sim.f
src/fgn_pkg.sv
src/fgn_if.sv
src/fgn_ctrl.sv
src/fgn_dp.sv
src/fractal_gradient_noise_3d.sv
src/fgn_checker.sv
bench/fractal_gradient_noise_3d_tb.sv
